// ===== sv/rrf_pkg.sv =====
// Shared types and constants for the record range filter.
package rrf_pkg;

	localparam int unsigned VALUE_WIDTH_DEF = 32;
	localparam int unsigned CE_WIDTH = 6;
	localparam int unsigned MODE_WIDTH = 5;
	localparam int unsigned CFG_INDEX_WIDTH = 3;

	// compare_enable bits
	localparam int unsigned CE_EQ = 0;
	localparam int unsigned CE_NE = 1;
	localparam int unsigned CE_LT = 2;
	localparam int unsigned CE_GT = 3;
	localparam int unsigned CE_MIN = 4;
	localparam int unsigned CE_MAX = 5;

	// mode_flags bits
	localparam int unsigned MODE_OR = 0;
	localparam int unsigned MODE_SORTED = 1;
	localparam int unsigned MODE_INVERT = 2;
	localparam int unsigned MODE_FIRST = 3;
	localparam int unsigned MODE_ALL = 4;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_COMPARE_ENABLE = 3'd0,
		REG_MODE_FLAGS     = 3'd1,
		REG_EQ_VALUE       = 3'd2,
		REG_NE_VALUE       = 3'd3,
		REG_LT_BOUND       = 3'd4,
		REG_GT_BOUND       = 3'd5,
		REG_MIN_INCL       = 3'd6,
		REG_MAX_INCL       = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic ok;
		logic done;
	} key_verdict_t;

endpackage

// ===== sv/rrf_if.sv =====
// Handshake channels for key items and result items.
interface rrf_key_if #(
	parameter int unsigned VALUE_WIDTH = rrf_pkg::VALUE_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] key_value;
	logic                          last_key;

	modport source (output valid, output key_value, output last_key, input ready);
	modport sink (input valid, input key_value, input last_key, output ready);
endinterface

interface rrf_res_if;
	logic valid;
	logic ready;
	logic emit;
	logic match_bit;
	logic stop;

	modport source (output valid, output emit, output match_bit, output stop, input ready);
	modport sink (input valid, input emit, input match_bit, input stop, output ready);
endinterface

// ===== sv/rrf_key_check.sv =====
// Per-key constraint check: key verdict and sorted-input done flag.
module rrf_key_check #(
	parameter int unsigned VALUE_WIDTH = rrf_pkg::VALUE_WIDTH_DEF
) (
	input  logic signed [VALUE_WIDTH-1:0]     key_value,
	input  logic [rrf_pkg::CE_WIDTH-1:0]      compare_enable,
	input  logic                              sorted,
	input  logic signed [VALUE_WIDTH-1:0]     eq_value,
	input  logic signed [VALUE_WIDTH-1:0]     ne_value,
	input  logic signed [VALUE_WIDTH-1:0]     lt_bound,
	input  logic signed [VALUE_WIDTH-1:0]     gt_bound,
	input  logic signed [VALUE_WIDTH-1:0]     min_incl,
	input  logic signed [VALUE_WIDTH-1:0]     max_incl,
	output rrf_pkg::key_verdict_t             verdict
);

	logic eq_hit, ne_hit, lt_hit, gt_hit, min_hit, max_hit;
	logic above_eq;

	always_comb begin
		eq_hit   = (key_value == eq_value);
		ne_hit   = (key_value != ne_value);
		lt_hit   = (key_value < lt_bound);
		gt_hit   = (key_value > gt_bound);
		min_hit  = (key_value >= min_incl);
		max_hit  = (key_value <= max_incl);
		above_eq = (key_value > eq_value);

		verdict.ok = (!compare_enable[rrf_pkg::CE_EQ]  || eq_hit)
			&& (!compare_enable[rrf_pkg::CE_NE]  || ne_hit)
			&& (!compare_enable[rrf_pkg::CE_LT]  || lt_hit)
			&& (!compare_enable[rrf_pkg::CE_GT]  || gt_hit)
			&& (!compare_enable[rrf_pkg::CE_MIN] || min_hit)
			&& (!compare_enable[rrf_pkg::CE_MAX] || max_hit);

		verdict.done = sorted && (
			(compare_enable[rrf_pkg::CE_MAX] && !max_hit)
			|| (compare_enable[rrf_pkg::CE_LT] && !lt_hit)
			|| (compare_enable[rrf_pkg::CE_EQ] && above_eq));
	end

endmodule

// ===== sv/record_range_filter.sv =====
// Record range filter: checks each key, combines verdicts, one result per record.
// A key item is registered on entry, and the record's result is registered from the input
// register when its last key leaves it; a result not yet taken by the sink can stall that step.
// Throughput: one key item per cycle; a last key waits in the input register while an
// earlier result is still waiting in the result register for the sink.
// Reset: asynchronous, active low; clears configuration, record accumulators and
// the stopped flag. After a stop, items are still taken but give no result.
module record_range_filter #(
	parameter int unsigned VALUE_WIDTH = rrf_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	rrf_key_if.sink                               keys,
	rrf_res_if.source                             results,
	input  logic                                  cfg_wr_en,
	input  logic [rrf_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  logic [VALUE_WIDTH-1:0]                cfg_data
);

	// configuration
	logic [rrf_pkg::CE_WIDTH-1:0]   compare_enable_q;
	logic [rrf_pkg::MODE_WIDTH-1:0] mode_flags_q;
	logic signed [VALUE_WIDTH-1:0]  eq_value_q, ne_value_q, lt_bound_q;
	logic signed [VALUE_WIDTH-1:0]  gt_bound_q, min_incl_q, max_incl_q;

	// input stage
	logic                          valid_s1;
	logic signed [VALUE_WIDTH-1:0] key_s1;
	logic                          last_s1;

	// record state
	logic all_match_q, any_match_q, all_done_q, any_done_q, stopped_q;

	// result register
	logic out_valid_q, emit_q, match_q, stop_q;

	rrf_pkg::key_verdict_t verdict;
	logic examine, advance, gives_result, in_ready;
	logic all_match_d, any_match_d, all_done_d, any_done_d;
	logic or_mode, rec_done, rec_verdict, match, emit, stop;

	rrf_key_check #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_check (
		.key_value     (key_s1),
		.compare_enable(compare_enable_q),
		.sorted        (mode_flags_q[rrf_pkg::MODE_SORTED]),
		.eq_value      (eq_value_q),
		.ne_value      (ne_value_q),
		.lt_bound      (lt_bound_q),
		.gt_bound      (gt_bound_q),
		.min_incl      (min_incl_q),
		.max_incl      (max_incl_q),
		.verdict       (verdict)
	);

	always_comb begin
		or_mode = mode_flags_q[rrf_pkg::MODE_OR];
		examine = (compare_enable_q != '0) || mode_flags_q[rrf_pkg::MODE_SORTED];

		all_match_d = all_match_q;
		any_match_d = any_match_q;
		all_done_d  = all_done_q;
		any_done_d  = any_done_q;
		if (examine) begin
			all_match_d = all_match_q && verdict.ok;
			any_match_d = any_match_q || verdict.ok;
			all_done_d  = all_done_q && verdict.done;
			any_done_d  = any_done_q || verdict.done;
		end

		rec_done    = or_mode ? all_done_d : any_done_d;
		rec_verdict = or_mode ? any_match_d : all_match_d;
		match = rec_verdict ^ mode_flags_q[rrf_pkg::MODE_INVERT];
		emit  = match || mode_flags_q[rrf_pkg::MODE_ALL];
		stop  = emit && mode_flags_q[rrf_pkg::MODE_FIRST];
		if (rec_done) begin
			emit  = 1'b0;
			match = 1'b0;
			stop  = 1'b1;
		end

		gives_result = valid_s1 && last_s1 && !stopped_q;
		advance  = valid_s1 && (!gives_result || !out_valid_q || results.ready);
		in_ready = !valid_s1 || advance;
	end

	assign keys.ready        = in_ready;
	assign results.valid     = out_valid_q;
	assign results.emit      = emit_q;
	assign results.match_bit = match_q;
	assign results.stop      = stop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compare_enable_q <= '0;
			mode_flags_q     <= '0;
			eq_value_q       <= '0;
			ne_value_q       <= '0;
			lt_bound_q       <= '0;
			gt_bound_q       <= '0;
			min_incl_q       <= '0;
			max_incl_q       <= '0;
		end else if (cfg_wr_en) begin
			case (rrf_pkg::reg_index_t'(cfg_index))
				rrf_pkg::REG_COMPARE_ENABLE: compare_enable_q <= cfg_data[rrf_pkg::CE_WIDTH-1:0];
				rrf_pkg::REG_MODE_FLAGS:     mode_flags_q <= cfg_data[rrf_pkg::MODE_WIDTH-1:0];
				rrf_pkg::REG_EQ_VALUE:       eq_value_q <= cfg_data;
				rrf_pkg::REG_NE_VALUE:       ne_value_q <= cfg_data;
				rrf_pkg::REG_LT_BOUND:       lt_bound_q <= cfg_data;
				rrf_pkg::REG_GT_BOUND:       gt_bound_q <= cfg_data;
				rrf_pkg::REG_MIN_INCL:       min_incl_q <= cfg_data;
				rrf_pkg::REG_MAX_INCL:       max_incl_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= keys.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && keys.valid) begin
			key_s1  <= keys.key_value;
			last_s1 <= keys.last_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			all_match_q <= 1'b1;
			any_match_q <= 1'b0;
			all_done_q  <= 1'b1;
			any_done_q  <= 1'b0;
			stopped_q   <= 1'b0;
		end else if (advance && !stopped_q) begin
			if (last_s1) begin
				all_match_q <= 1'b1;
				any_match_q <= 1'b0;
				all_done_q  <= 1'b1;
				any_done_q  <= 1'b0;
				stopped_q   <= stop;
			end else begin
				all_match_q <= all_match_d;
				any_match_q <= any_match_d;
				all_done_q  <= all_done_d;
				any_done_q  <= any_done_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && gives_result) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && gives_result) begin
			emit_q  <= emit;
			match_q <= match;
			stop_q  <= stop;
		end
	end

endmodule
